### rtl/core/zrapd_pkg.sv
`timescale 1ns / 1ps
package zrapd_pkg;

	// verdict codes
	localparam logic [2:0] V_TOO_SHORT   = 3'd0;
	localparam logic [2:0] V_NOT_PATTERN = 3'd1;
	localparam logic [2:0] V_FULL        = 3'd2;
	localparam logic [2:0] V_HALF        = 3'd3;
	localparam logic [2:0] V_HALF_MIX    = 3'd4;

	// configuration register indexes
	localparam logic REG_SAMPLE_RATE = 1'b0;
	localparam logic REG_FRAME_WORDS = 1'b1;

	localparam int RATE_BITS   = 18;
	localparam int FRAME_BITS  = 4;
	localparam int THR_BITS    = 11;
	localparam int MAX_FRAME   = 8;

	localparam logic [RATE_BITS-1:0]  RATE_RESET  = 18'd48000;
	localparam logic [FRAME_BITS-1:0] FRAME_RESET = 4'd2;

	localparam logic [7:0] HALF_MARK = 8'h80;

	// upper sum bound: 100000 * S <= 99479 * N
	localparam logic [16:0] SUM_HI_MUL = 17'd100000;
	localparam logic [16:0] SUM_LO_MUL = 17'd99479;

	// ceil(2^20 / 25), exact for 15-bit operands
	localparam logic [15:0] RECIP_25 = 16'd41944;

	// floor(rate / 200) as (rate >> 3) / 25 through a reciprocal
	function automatic logic [THR_BITS-1:0] rate_threshold(input logic [RATE_BITS-1:0] rate);
		logic [30:0] prod;
		prod = 31'(rate[RATE_BITS-1:3]) * 31'(RECIP_25);
		return prod[30:20];
	endfunction

endpackage

### rtl/core/zrapd_if.sv
`timescale 1ns / 1ps
interface zrapd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] audio_word;
	logic               last_word;

	modport source (output valid, output audio_word, output last_word, input ready);
	modport sink (input valid, input audio_word, input last_word, output ready);
endinterface

interface zrapd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

### rtl/core/zrapd_fifo.sv
`timescale 1ns / 1ps
module zrapd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### rtl/core/zrapd_front.sv
`timescale 1ns / 1ps
module zrapd_front #(
	parameter int COUNT_BITS = 26,
	parameter int SNAP_W     = 13 * COUNT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	zrapd_in_if.sink                            in_ch,
	input  logic [zrapd_pkg::RATE_BITS-1:0]     sample_rate,
	input  logic [zrapd_pkg::FRAME_BITS-1:0]    frame_words,
	input  logic                                queue_full,
	output logic                                push,
	output logic [SNAP_W-1:0]                   snap
);
	localparam int C = COUNT_BITS;

	logic [2:0]     word_pos_q;
	logic [C-1:0]   frame_cnt_q;
	logic [C-1:0]   run_q [3];
	logic [C-1:0]   blk_q [3];
	logic [C-1:0]   sum_q [3];
	logic [2*C-1:0] sq_sum_q [3];
	logic [2*C-1:0] sq_s1 [3];
	logic [2:0]     add_s1;
	logic           pend_s1;

	logic [2*C-1:0] sq_next [3];
	logic [2*C:0]   sq_wide [3];
	logic [2:0]     hit;
	logic [C-1:0]   thr;
	logic [3:0]     fw;
	logic [3:0]     pos_inc;
	logic           acc;

	assign in_ch.ready = !pend_s1 && !queue_full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign push        = pend_s1;

	assign hit[0] = (in_ch.audio_word == '0);
	assign hit[1] = (in_ch.audio_word[15:8] == zrapd_pkg::HALF_MARK);
	assign hit[2] = (in_ch.audio_word[7:0] == zrapd_pkg::HALF_MARK);
	assign thr    = C'(zrapd_pkg::rate_threshold(sample_rate));

	always_comb begin
		if (frame_words == '0) begin
			fw = 4'd1;
		end else if (frame_words > 4'(zrapd_pkg::MAX_FRAME)) begin
			fw = 4'(zrapd_pkg::MAX_FRAME);
		end else begin
			fw = frame_words;
		end
		pos_inc = {1'b0, word_pos_q} + 4'd1;
	end

	// the squares are registered, so square sums are added in the cycle after the word
	always_comb begin
		for (int v = 0; v < 3; v++) begin
			sq_wide[v] = {1'b0, sq_sum_q[v]} + {1'b0, sq_s1[v]};
			if (!add_s1[v]) begin
				sq_next[v] = sq_sum_q[v];
			end else if (sq_wide[v][2*C]) begin
				sq_next[v] = '1;
			end else begin
				sq_next[v] = sq_wide[v][2*C-1:0];
			end
		end
	end

	always_comb begin
		snap[C-1:0] = frame_cnt_q;
		for (int v = 0; v < 3; v++) begin
			snap[C*(1+v) +: C]       = blk_q[v];
			snap[C*(4+v) +: C]       = sum_q[v];
			snap[7*C + 2*C*v +: 2*C] = sq_next[v];
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < 3; v++) begin
			sq_s1[v] <= (2*C)'(run_q[v]) * (2*C)'(run_q[v]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos_q  <= '0;
			frame_cnt_q <= '0;
			add_s1      <= '0;
			pend_s1     <= 1'b0;
			for (int v = 0; v < 3; v++) begin
				run_q[v]    <= '0;
				blk_q[v]    <= '0;
				sum_q[v]    <= '0;
				sq_sum_q[v] <= '0;
			end
		end else begin
			pend_s1 <= acc && in_ch.last_word;
			add_s1  <= '0;
			for (int v = 0; v < 3; v++) begin
				sq_sum_q[v] <= pend_s1 ? '0 : sq_next[v];
			end
			if (pend_s1) begin
				word_pos_q  <= '0;
				frame_cnt_q <= '0;
				for (int v = 0; v < 3; v++) begin
					run_q[v] <= '0;
					blk_q[v] <= '0;
					sum_q[v] <= '0;
				end
			end else if (acc) begin
				word_pos_q <= (pos_inc >= fw) ? '0 : pos_inc[2:0];
				if (word_pos_q == '0) begin
					if (frame_cnt_q != '1) begin
						frame_cnt_q <= frame_cnt_q + 1'b1;
					end
					for (int v = 0; v < 3; v++) begin
						if (hit[v]) begin
							if (run_q[v] != '1) begin
								run_q[v] <= run_q[v] + 1'b1;
							end
						end else begin
							if (run_q[v] >= thr) begin
								add_s1[v] <= 1'b1;
								if (blk_q[v] != '1) begin
									blk_q[v] <= blk_q[v] + 1'b1;
								end
								if (sum_q[v] > ~run_q[v]) begin
									sum_q[v] <= '1;
								end else begin
									sum_q[v] <= sum_q[v] + run_q[v];
								end
							end
							run_q[v] <= '0;
						end
					end
				end
			end
		end
	end
endmodule

### rtl/core/zrapd_mul.sv
`timescale 1ns / 1ps
module zrapd_mul #(
	parameter int A_W = 78,
	parameter int B_W = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);
	localparam int P_W = A_W + B_W;

	logic           busy_q;
	logic [P_W-1:0] acc_q;
	logic [P_W-1:0] ash_q;
	logic [B_W-1:0] b_q;

	// shift-add, one multiplier bit a cycle, stops once the rest is zero
	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= P_W'(a);
			b_q   <= b;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + ash_q;
			end
			ash_q <= {ash_q[P_W-2:0], 1'b0};
			b_q   <= {1'b0, b_q[B_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end
endmodule

### rtl/core/zrapd_back.sv
`timescale 1ns / 1ps
module zrapd_back #(
	parameter int COUNT_BITS = 26,
	parameter int SNAP_W     = 13 * COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [zrapd_pkg::RATE_BITS-1:0] sample_rate,
	input  logic                            queue_empty,
	input  logic [SNAP_W-1:0]               snap,
	output logic                            pop,
	zrapd_out_if.source                     out_ch
);
	localparam int C   = COUNT_BITS;
	localparam int A_W = 3 * C;
	localparam int B_W = C + 2;
	localparam int P_W = A_W + B_W;
	localparam int K_W = C + 3;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHK   = 6'b000010,
		ST_START = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_MINB,
		OP_HI,
		OP_LO,
		OP_S2,
		OP_NQ,
		OP_DN,
		OP_RHS
	} op_t;

	state_t         state_q;
	op_t            op_q;
	op_t            op_nx;
	logic [1:0]     view_q;
	logic [2:0]     pass_q;
	logic [2:0]     verdict_q;
	logic [C-1:0]   frame_q;
	logic [C-1:0]   blk_q [3];
	logic [C-1:0]   sum_q [3];
	logic [2*C-1:0] sqs_q [3];
	logic [P_W-1:0] hi_q;
	logic [2*C-1:0] s2_q;
	logic [P_W-1:0] tmp_q;

	logic [C-1:0]   n_sel;
	logic [C-1:0]   s_sel;
	logic [2*C-1:0] q_sel;
	logic [P_W-1:0] dev;
	logic [A_W-1:0] mul_a;
	logic [B_W-1:0] mul_b;
	logic           mul_start;
	logic           mul_done;
	logic [P_W-1:0] prod;
	logic           vend;
	logic           vpass;
	logic           minb_fail;
	logic           low_fail;
	logic           too_short;
	logic [K_W-1:0] s6;
	logic [K_W-1:0] n5;

	assign pop            = (state_q == ST_IDLE) && !queue_empty;
	assign mul_start      = (state_q == ST_START);
	assign out_ch.valid   = (state_q == ST_OUT);
	assign out_ch.verdict = verdict_q;

	assign n_sel = blk_q[view_q];
	assign s_sel = sum_q[view_q];
	assign q_sel = sqs_q[view_q];

	assign n5        = K_W'({frame_q, 2'b00}) + K_W'(frame_q);
	assign too_short = n5 < K_W'(sample_rate);
	assign s6        = K_W'({s_sel, 2'b00}) + K_W'({s_sel, 1'b0});
	assign low_fail  = (view_q == 2'd0) ? (K_W'({s_sel, 1'b0}) < K_W'(frame_q))
		: (s6 < K_W'(frame_q));
	// n < floor(16N / rate) is (n + 1) * rate <= 16N
	assign minb_fail = (sample_rate != '0) && (prod <= P_W'({frame_q, 4'b0000}));
	assign dev       = (tmp_q > P_W'(s2_q)) ? tmp_q - P_W'(s2_q) : '0;

	always_comb begin
		unique case (op_q)
			OP_MINB: begin
				mul_a = A_W'(n_sel) + A_W'(1);
				mul_b = B_W'(sample_rate);
			end
			OP_HI: begin
				mul_a = A_W'(s_sel);
				mul_b = B_W'(zrapd_pkg::SUM_HI_MUL);
			end
			OP_LO: begin
				mul_a = A_W'(frame_q);
				mul_b = B_W'(zrapd_pkg::SUM_LO_MUL);
			end
			OP_S2: begin
				mul_a = A_W'(s_sel);
				mul_b = B_W'(s_sel);
			end
			OP_NQ: begin
				mul_a = A_W'(q_sel);
				mul_b = B_W'(n_sel);
			end
			OP_DN: begin
				mul_a = A_W'(dev);
				mul_b = B_W'(n_sel);
			end
			OP_RHS: begin
				mul_a = A_W'(s2_q);
				mul_b = B_W'(n_sel - C'(1));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		vend  = 1'b0;
		vpass = 1'b0;
		op_nx = op_q;
		unique case (op_q)
			OP_MINB: begin
				if (minb_fail || low_fail) begin
					vend = 1'b1;
				end else begin
					op_nx = OP_HI;
				end
			end
			OP_HI: op_nx = OP_LO;
			OP_LO: begin
				if (hi_q > prod) begin
					vend = 1'b1;
				end else if (n_sel < C'(2)) begin
					vend  = 1'b1;
					vpass = 1'b1;
				end else begin
					op_nx = OP_S2;
				end
			end
			OP_S2: op_nx = OP_NQ;
			OP_NQ: op_nx = OP_DN;
			OP_DN: op_nx = OP_RHS;
			OP_RHS: begin
				// 16 * n * dev <= (n - 1) * S^2
				vend  = 1'b1;
				vpass = {tmp_q, 4'b0000} <= (P_W + 4)'(prod);
			end
			default: vend = 1'b1;
		endcase
	end

	zrapd_mul #(
		.A_W(A_W),
		.B_W(B_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (prod)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= snap[C-1:0];
			for (int v = 0; v < 3; v++) begin
				blk_q[v] <= snap[C*(1+v) +: C];
				sum_q[v] <= snap[C*(4+v) +: C];
				sqs_q[v] <= snap[7*C + 2*C*v +: 2*C];
			end
		end
		if (state_q == ST_MUL && mul_done) begin
			unique case (op_q)
				OP_HI: hi_q <= prod;
				OP_S2: s2_q <= prod[2*C-1:0];
				OP_NQ, OP_DN: tmp_q <= prod;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_MINB;
			view_q    <= '0;
			pass_q    <= '0;
			verdict_q <= zrapd_pkg::V_TOO_SHORT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (too_short) begin
						verdict_q <= zrapd_pkg::V_TOO_SHORT;
						state_q   <= ST_OUT;
					end else begin
						view_q  <= '0;
						pass_q  <= '0;
						op_q    <= OP_MINB;
						state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_done) begin
						if (vend) begin
							pass_q[view_q] <= vpass;
							if (view_q == 2'd2) begin
								state_q <= ST_FIN;
							end else begin
								view_q  <= view_q + 1'b1;
								op_q    <= OP_MINB;
								state_q <= ST_START;
							end
						end else begin
							op_q    <= op_nx;
							state_q <= ST_START;
						end
					end
				end
				ST_FIN: begin
					if (pass_q[2] && pass_q[1]) begin
						verdict_q <= zrapd_pkg::V_HALF_MIX;
					end else if (pass_q[1]) begin
						verdict_q <= zrapd_pkg::V_HALF;
					end else if (pass_q[0]) begin
						verdict_q <= zrapd_pkg::V_FULL;
					end else begin
						verdict_q <= zrapd_pkg::V_NOT_PATTERN;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/zero_run_audio_pattern_detector_top.sv
`timescale 1ns / 1ps
// words are taken one per cycle while the queue is not full; the cycle after a last word
// the front is busy handing its totals over
// a verdict takes up to 7 serial multiplies per view, for each of the three views in turn
// a queue of QUEUE_DEPTH buffers lets the front keep taking words while a verdict is worked out
// arst_n clears all counters and the queue; sample_rate resets to 48000, frame_words to 2
module zero_run_audio_pattern_detector_top #(
	parameter int COUNT_BITS  = 26,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	zrapd_in_if.sink                        in_ch,
	zrapd_out_if.source                     out_ch,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [zrapd_pkg::RATE_BITS-1:0] cfg_data
);
	localparam int SNAP_W = 13 * COUNT_BITS;

	logic [zrapd_pkg::RATE_BITS-1:0]  sample_rate_q;
	logic [zrapd_pkg::FRAME_BITS-1:0] frame_words_q;
	logic                             push;
	logic                             pop;
	logic                             queue_full;
	logic                             queue_empty;
	logic [SNAP_W-1:0]                snap_in;
	logic [SNAP_W-1:0]                snap_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= zrapd_pkg::RATE_RESET;
			frame_words_q <= zrapd_pkg::FRAME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zrapd_pkg::REG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				zrapd_pkg::REG_FRAME_WORDS: frame_words_q <= cfg_data[zrapd_pkg::FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	zrapd_front #(
		.COUNT_BITS(COUNT_BITS),
		.SNAP_W    (SNAP_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.sample_rate(sample_rate_q),
		.frame_words(frame_words_q),
		.queue_full (queue_full),
		.push       (push),
		.snap       (snap_in)
	);

	zrapd_fifo #(
		.WIDTH(SNAP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (snap_in),
		.pop   (pop),
		.rdata (snap_out),
		.full  (queue_full),
		.empty (queue_empty)
	);

	zrapd_back #(
		.COUNT_BITS(COUNT_BITS),
		.SNAP_W    (SNAP_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_rate(sample_rate_q),
		.queue_empty(queue_empty),
		.snap       (snap_out),
		.pop        (pop),
		.out_ch     (out_ch)
	);
endmodule

### rtl/core/zrapd_checker.sv
`timescale 1ns / 1ps
module zrapd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] verdict
);
	// a stalled verdict word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict))
		else $error("verdict word changed while stalled");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == zrapd_pkg::V_TOO_SHORT || verdict == zrapd_pkg::V_NOT_PATTERN
			|| verdict == zrapd_pkg::V_FULL || verdict == zrapd_pkg::V_HALF
			|| verdict == zrapd_pkg::V_HALF_MIX))
		else $error("verdict code out of range");

	// the front hands its totals over in the cycle after a last word
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("word taken during buffer hand-over");

	// handshake outputs and a shown verdict are never unknown
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid}) && (!out_valid || !$isunknown(verdict)))
		else $error("unknown value on output handshake");
endmodule

bind zero_run_audio_pattern_detector_top zrapd_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_last  (in_ch.last_word),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.verdict  (out_ch.verdict)
);
